### rtl/core/compass_edge_gradient_3x3_top_macros.svh
// ----------------------------------------------------------------------------
// Compass edge gradient assertion macros
// Concurrent checks on the rising clock edge, muted during reset.
// ----------------------------------------------------------------------------
`ifndef COMPASS_EDGE_GRADIENT_3X3_TOP_MACROS_SVH
`define COMPASS_EDGE_GRADIENT_3X3_TOP_MACROS_SVH

// check a property that holds in the same cycle
`define CEGR_CHECK_NOW(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check an implication that spans cycles
`define CEGR_CHECK_SEQ(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

### rtl/core/cegr_pkg.sv
// ----------------------------------------------------------------------------
// Compass edge gradient package
// Widths, register indexes, emit kinds and the compass kernel tables.
// ----------------------------------------------------------------------------
package cegr_pkg;

   localparam int PIXEL_BITS = 16;
   localparam int MAX_WIDTH  = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = 16;
   localparam int IW_W       = 11;
   localparam int ACC_W      = PIXEL_BITS + 6;
   localparam int MAG_W      = 24;
   localparam int DIR_W      = 4;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;

   localparam logic [1:0] REG_KERNEL_SET   = 2'd0;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

   // emit kinds, in output order
   localparam int EMIT_UP_MID   = 0;
   localparam int EMIT_LAST_MID = 1;
   localparam int EMIT_UP_LAST  = 2;
   localparam int EMIT_LAST_LAST = 3;

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             fend;
   } meta_type;

   localparam logic signed [3:0] KERNELS [4][8][9] = '{
      '{ '{ 1, 1,-1,  1,-2,-1,  1, 1,-1}, '{ 1,-1,-1,  1,-2,-1,  1, 1, 1},
         '{-1,-1,-1,  1,-2, 1,  1, 1, 1}, '{-1,-1, 1, -1,-2, 1,  1, 1, 1},
         '{-1, 1, 1, -1,-2, 1, -1, 1, 1}, '{ 1, 1, 1, -1,-2, 1, -1,-1, 1},
         '{ 1, 1, 1,  1,-2, 1, -1,-1,-1}, '{ 1, 1, 1,  1,-2,-1,  1,-1,-1} },
      '{ '{ 5,-3,-3,  5, 0,-3,  5,-3,-3}, '{-3,-3,-3,  5, 0,-3,  5, 5,-3},
         '{-3,-3,-3, -3, 0,-3,  5, 5, 5}, '{-3,-3,-3, -3, 0, 5, -3, 5, 5},
         '{-3,-3, 5, -3, 0, 5, -3,-3, 5}, '{-3, 5, 5, -3, 0, 5, -3,-3,-3},
         '{ 5, 5, 5, -3, 0,-3, -3,-3,-3}, '{ 5, 5,-3,  5, 0,-3, -3,-3,-3} },
      '{ '{ 1, 0,-1,  1, 0,-1,  1, 0,-1}, '{ 0,-1,-1,  1, 0,-1,  1, 1, 0},
         '{-1,-1,-1,  0, 0, 0,  1, 1, 1}, '{-1,-1, 0, -1, 0, 1,  0, 1, 1},
         '{-1, 0, 1, -1, 0, 1, -1, 0, 1}, '{ 0, 1, 1, -1, 0, 1, -1,-1, 0},
         '{ 1, 1, 1,  0, 0, 0, -1,-1,-1}, '{ 1, 1, 0,  1, 0,-1,  0,-1,-1} },
      '{ '{ 1, 0,-1,  2, 0,-2,  1, 0,-1}, '{ 0,-1,-2,  1, 0,-1,  2, 1, 0},
         '{-1,-2,-1,  0, 0, 0,  1, 2, 1}, '{-2,-1, 0, -1, 0, 1,  0, 1, 2},
         '{-1, 0, 1, -2, 0, 2, -1, 0, 1}, '{ 0, 1, 2, -1, 0, 1, -2,-1, 0},
         '{ 1, 2, 1,  0, 0, 0, -1,-2,-1}, '{ 2, 1, 0,  1, 0,-1,  0,-1,-2} }
   };

   localparam logic [3:0] SET_SCALE [4] = '{4'd5, 4'd15, 4'd3, 4'd4};

endpackage

### rtl/core/cegr_ram.sv
// ----------------------------------------------------------------------------
// Compass edge gradient line RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cegr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

### rtl/core/compass_edge_gradient_3x3_top.sv
// ----------------------------------------------------------------------------
// Compass edge gradient 3x3 top level
// Line-buffered 3x3 compass edge detector with mirrored borders.
// ----------------------------------------------------------------------------
// Takes one signed pixel per clock in raster order, unless the request side is
// held, and returns, per pixel, the scaled largest compass response and its
// 1-based direction, one row and one column behind the input. A pixel past the
// first row and column that completes a row end or the last row yields two or
// four results; the single convolution pipe emits one result per clock while
// the output is not stalled, so such a pixel holds the request side until its
// extra results have issued. Two line RAMs hold the previous rows, read at the
// column of each request and written back as it leaves the first stage.
module compass_edge_gradient_3x3_top
   import cegr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [PIXEL_BITS-1:0] req_pixel,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [MAG_W-1:0]        rsp_magnitude,
   output logic [DIR_W-1:0]        rsp_direction,
   output logic [ROW_W-1:0]        rsp_out_row,
   output logic [COL_W-1:0]        rsp_out_col,
   output logic                    rsp_frame_end,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   `include "compass_edge_gradient_3x3_top_macros.svh"

   logic [1:0]       kset_ff;
   logic [IW_W-1:0]  iwidth_ff;
   logic [ROW_W-1:0] iheight_ff;

   logic [COL_W-1:0] wm1;
   logic [ROW_W-1:0] hm1;
   logic [COL_W-1:0] col_ff, col_in, c_sat;
   logic [ROW_W-1:0] row_ff, row_in, r_sat;
   logic             accept, en, lastc, lastr;

   logic             s1_valid_ff;
   pixel_type        s1_pixel_ff;
   logic [COL_W-1:0] s1_c_ff;
   logic [ROW_W-1:0] s1_r_ff;
   logic             s1_lastc_ff, s1_lastr_ff;
   logic             s1_take;
   logic [COL_W-1:0] raddr;
   logic [PIXEL_BITS-1:0] up_raw, old_raw;

   pixel_type        win_ff [3][3];
   logic [3:0]       s2_mask_ff, s2_mask_in, new_mask;
   logic [ROW_W-1:0] s2_r_ff;
   logic [COL_W-1:0] s2_c_ff;
   logic             s2_rmir_ff, s2_cmir_ff, s2_free, s2_issue;
   logic [1:0]       kind;
   logic [1:0]       rsel [3];
   logic [1:0]       csel [3];
   meta_type         meta_sel;

   logic             s3_valid_ff;
   pixel_type        s3_g_ff [3][3];
   meta_type         s3_meta_ff;

   logic             s4_valid_ff;
   logic signed [ACC_W-1:0] s4_acc_ff [8];
   logic signed [ACC_W-1:0] acc_in [8];
   meta_type         s4_meta_ff;

   logic             s5_valid_ff;
   logic [ACC_W-1:0] s5_best_ff, best_in, mabs;
   logic [DIR_W-1:0] s5_dir_ff, dir_in;
   meta_type         s5_meta_ff;

   logic [ACC_W+3:0] prod;
   logic [MAG_W-1:0] mag_in;
   logic             csr_we;

   // configuration port
   assign pready = 1'b1;
   assign csr_we = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         kset_ff    <= 2'd1;
         iwidth_ff  <= IW_W'(MAX_WIDTH);
         iheight_ff <= ROW_W'(1024);
      end else if (csr_we) begin
         unique case (paddr[3:2])
            REG_KERNEL_SET:   kset_ff    <= pwdata[1:0];
            REG_IMAGE_WIDTH:  iwidth_ff  <= pwdata[IW_W-1:0];
            REG_IMAGE_HEIGHT: iheight_ff <= pwdata[ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_KERNEL_SET:   prdata = DATA_W'(kset_ff);
         REG_IMAGE_WIDTH:  prdata = DATA_W'(iwidth_ff);
         REG_IMAGE_HEIGHT: prdata = DATA_W'(iheight_ff);
         default:          prdata = '0;
      endcase
   end

   // geometry and counters
   always_comb begin
      if (iwidth_ff < IW_W'(2)) begin
         wm1 = COL_W'(1);
      end else if (iwidth_ff > IW_W'(MAX_WIDTH)) begin
         wm1 = COL_W'(MAX_WIDTH - 1);
      end else begin
         wm1 = COL_W'(iwidth_ff - IW_W'(1));
      end
      hm1 = (iheight_ff < ROW_W'(2)) ? ROW_W'(1) : iheight_ff - ROW_W'(1);
      c_sat = (col_ff > wm1) ? wm1 : col_ff;
      r_sat = (row_ff > hm1) ? hm1 : row_ff;
      lastc = (c_sat == wm1);
      lastr = (r_sat == hm1);
      if (lastc) begin
         col_in = '0;
         row_in = lastr ? '0 : r_sat + ROW_W'(1);
      end else begin
         col_in = c_sat + COL_W'(1);
         row_in = r_sat;
      end
   end

   assign en        = !rsp_valid || rsp_ready;
   assign s2_free   = ((s2_mask_ff & (s2_mask_ff - 4'd1)) == 4'd0);
   assign s1_take   = en && s1_valid_ff && s2_free;
   assign req_ready = !s1_valid_ff || s1_take;
   assign accept    = req_valid && req_ready;
   assign raddr     = accept ? c_sat : s1_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_take) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_pixel;
         s1_c_ff     <= c_sat;
         s1_r_ff     <= r_sat;
         s1_lastc_ff <= lastc;
         s1_lastr_ff <= lastr;
      end
   end

   cegr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_prev_ram (
      .clock (clock),
      .we    (s1_take),
      .waddr (s1_c_ff),
      .wdata (s1_pixel_ff),
      .raddr (raddr),
      .rdata (up_raw)
   );

   cegr_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_older_ram (
      .clock (clock),
      .we    (s1_take),
      .waddr (s1_c_ff),
      .wdata (up_raw),
      .raddr (raddr),
      .rdata (old_raw)
   );

   // window and emit list
   always_comb begin
      new_mask = '0;
      new_mask[EMIT_UP_MID]    = (s1_r_ff != '0) && (s1_c_ff != '0);
      new_mask[EMIT_LAST_MID]  = (s1_r_ff != '0) && (s1_c_ff != '0) && s1_lastr_ff;
      new_mask[EMIT_UP_LAST]   = (s1_r_ff != '0) && s1_lastc_ff;
      new_mask[EMIT_LAST_LAST] = (s1_r_ff != '0) && s1_lastc_ff && s1_lastr_ff;
   end

   assign s2_issue = en && (s2_mask_ff != '0);

   always_comb begin
      if (s2_mask_ff[EMIT_UP_MID]) begin
         kind = 2'(EMIT_UP_MID);
      end else if (s2_mask_ff[EMIT_LAST_MID]) begin
         kind = 2'(EMIT_LAST_MID);
      end else if (s2_mask_ff[EMIT_UP_LAST]) begin
         kind = 2'(EMIT_UP_LAST);
      end else begin
         kind = 2'(EMIT_LAST_LAST);
      end
      s2_mask_in = s2_mask_ff;
      if (s2_issue) begin
         s2_mask_in[kind] = 1'b0;
      end
      if (s1_take) begin
         s2_mask_in = new_mask;
      end
      if (kind == 2'(EMIT_UP_MID) || kind == 2'(EMIT_UP_LAST)) begin
         rsel[0] = s2_rmir_ff ? 2'd2 : 2'd0;
         rsel[1] = 2'd1;
         rsel[2] = 2'd2;
         meta_sel.row = s2_r_ff - ROW_W'(1);
      end else begin
         rsel[0] = 2'd1;
         rsel[1] = 2'd2;
         rsel[2] = 2'd1;
         meta_sel.row = s2_r_ff;
      end
      if (kind == 2'(EMIT_UP_MID) || kind == 2'(EMIT_LAST_MID)) begin
         csel[0] = s2_cmir_ff ? 2'd2 : 2'd0;
         csel[1] = 2'd1;
         csel[2] = 2'd2;
         meta_sel.col = s2_c_ff - COL_W'(1);
      end else begin
         csel[0] = 2'd1;
         csel[1] = 2'd2;
         csel[2] = 2'd1;
         meta_sel.col = s2_c_ff;
      end
      meta_sel.fend = (kind == 2'(EMIT_LAST_LAST));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_mask_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
               win_ff[a][b] <= '0;
            end
         end
      end else begin
         s2_mask_ff <= s2_mask_in;
         if (s1_take) begin
            for (int a = 0; a < 3; a++) begin
               win_ff[a][0] <= win_ff[a][1];
               win_ff[a][1] <= win_ff[a][2];
            end
            win_ff[0][2] <= old_raw;
            win_ff[1][2] <= up_raw;
            win_ff[2][2] <= s1_pixel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         s2_r_ff    <= s1_r_ff;
         s2_c_ff    <= s1_c_ff;
         s2_rmir_ff <= (s1_r_ff == ROW_W'(1));
         s2_cmir_ff <= (s1_c_ff == COL_W'(1));
      end
   end

   // convolution pipe
   always_comb begin
      for (int f = 0; f < 8; f++) begin
         acc_in[f] = '0;
         for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
               acc_in[f] = acc_in[f] + ACC_W'(KERNELS[kset_ff][f][a*3+b]
                           * s3_g_ff[2-a][2-b]);
            end
         end
      end
   end

   always_comb begin
      best_in = '0;
      dir_in  = '0;
      for (int f = 0; f < 8; f++) begin
         mabs = s4_acc_ff[f][ACC_W-1] ? ACC_W'(-s4_acc_ff[f]) : ACC_W'(s4_acc_ff[f]);
         if (mabs > best_in) begin
            best_in = mabs;
            dir_in  = DIR_W'(f + 1);
         end
      end
   end

   assign prod   = s5_best_ff * SET_SCALE[kset_ff];
   assign mag_in = (prod > (ACC_W+4)'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : MAG_W'(prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_mask_ff != '0;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         rsp_valid   <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
               s3_g_ff[a][b] <= win_ff[rsel[a]][csel[b]];
            end
         end
         s3_meta_ff    <= meta_sel;
         s4_acc_ff     <= acc_in;
         s4_meta_ff    <= s3_meta_ff;
         s5_best_ff    <= best_in;
         s5_dir_ff     <= dir_in;
         s5_meta_ff    <= s4_meta_ff;
         rsp_magnitude <= mag_in;
         rsp_direction <= s5_dir_ff;
         rsp_out_row   <= s5_meta_ff.row;
         rsp_out_col   <= s5_meta_ff.col;
         rsp_frame_end <= s5_meta_ff.fend;
      end
   end

   `CEGR_CHECK_NOW(a_zero_dir_zero_mag,
      !(rsp_valid && rsp_direction == '0) || rsp_magnitude == '0,
      "direction zero with nonzero magnitude")
   `CEGR_CHECK_NOW(a_frame_end_col,
      !(rsp_valid && rsp_frame_end) || rsp_out_col != '0,
      "frame end on column zero")
   `CEGR_CHECK_SEQ(a_accept_loads_s1, accept |=> s1_valid_ff,
      "accepted request not held in first stage")

endmodule
